FILE: rtl/clsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clsr_pkg;

  typedef logic [30:0] word_t;

  // moduli are 2^31 - FOLDx, so the bits above bit 30 fold back times FOLDx
  localparam word_t       MOD1         = 31'd2147483563;
  localparam word_t       MOD2         = 31'd2147483399;
  localparam word_t       SPAN         = 31'd2147483562;
  localparam logic [15:0] MUL1         = 16'd40014;
  localparam logic [15:0] MUL2         = 16'd40692;
  localparam logic [7:0]  FOLD1        = 8'd85;
  localparam logic [7:0]  FOLD2        = 8'd249;
  localparam word_t       SECOND_RESET = 31'd123456789;
  localparam int          WARMUP       = 8;

  // seed of zero or a multiple of MOD1 behaves as 1
  function automatic word_t reduce_seed(input word_t s);
    word_t r;
    r = (s >= MOD1) ? word_t'(s - MOD1) : s;
    if (r == '0) begin
      r = 31'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/clsr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module clsr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/clsr_lcg_pair.sv
`timescale 1ns / 1ps
`default_nettype none

// Both generators: product registered, then folded and reduced.
module clsr_lcg_pair (
  input  wire logic            clk_i,
  input  wire logic            mul_en_i,
  input  wire clsr_pkg::word_t x1_i,
  input  wire clsr_pkg::word_t x2_i,
  output clsr_pkg::word_t      x1_next_o,
  output clsr_pkg::word_t      x2_next_o
);

  logic [46:0] p1_q, p2_q;
  logic [31:0] s1, s2;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      p1_q <= 47'(x1_i) * 47'(clsr_pkg::MUL1);
      p2_q <= 47'(x2_i) * 47'(clsr_pkg::MUL2);
    end
  end

  // sum stays below twice the modulus, so one subtract finishes it
  always_comb begin
    s1 = 32'(p1_q[30:0]) + 32'(p1_q[46:31]) * 32'(clsr_pkg::FOLD1);
    s2 = 32'(p2_q[30:0]) + 32'(p2_q[46:31]) * 32'(clsr_pkg::FOLD2);
    x1_next_o = (s1 >= 32'(clsr_pkg::MOD1)) ? 31'(s1 - 32'(clsr_pkg::MOD1)) : s1[30:0];
    x2_next_o = (s2 >= 32'(clsr_pkg::MOD2)) ? 31'(s2 - 32'(clsr_pkg::MOD2)) : s2[30:0];
  end

endmodule

`default_nettype wire

FILE: rtl/clsr_index.sv
`timescale 1ns / 1ps
`default_nettype none

// Table index = last output / (1 + SPAN / TABLE_SIZE), by exact reciprocal
// multiply; one register stage, running every cycle.
module clsr_index #(
  parameter int TABLE_SIZE = 32,
  localparam int AW = $clog2(TABLE_SIZE)
) (
  input  wire logic            clk_i,
  input  wire clsr_pkg::word_t value_i,
  output logic [AW-1:0]        index_o
);

  localparam longint unsigned DIV   = 64'd1 + 64'd2147483562 / TABLE_SIZE;
  localparam int              L     = $clog2(DIV);
  localparam int              S     = 31 + L;
  localparam logic [63:0]     RECIP = ((64'd1 << S) + DIV - 64'd1) / DIV;
  localparam int              QW    = 64 - S;

  logic [63:0]   prod;
  logic [QW-1:0] quo_q;

  assign prod = {33'd0, value_i} * {31'd0, RECIP[32:0]};

  always_ff @(posedge clk_i) begin
    quo_q <= prod[63:S];
  end

  assign index_o = (quo_q >= QW'(TABLE_SIZE)) ? AW'(TABLE_SIZE - 1) : quo_q[AW-1:0];

endmodule

`default_nettype wire

FILE: rtl/combined_lcg_shuffle_rng.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload
// -------   ---------------------   ------------------------
// input     in_valid_i / in_ready_o reseed_i
// output    out_valid_o/out_ready_i value_o
// config    cfg_valid_i/cfg_ready_o seed_i
//
// A draw steps through product, fold plus table RAM read, and mix and write back.
// Seeding adds an init step and TABLE_SIZE+8 warm-up steps of the first
// generator, each through the modular multiplier.
// After reset the first request always seeds, so the table needs no clear.
// A full output register holds the last cycle of a draw; input is taken in
// the idle state or in that last cycle once the beat leaves.
module combined_lcg_shuffle_rng #(
  parameter int TABLE_SIZE = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        reseed_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [30:0]      value_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [30:0] seed_i
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + clsr_pkg::WARMUP);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SEED_INIT = 3'd1;
  localparam logic [2:0] ST_SEED_MUL  = 3'd2;
  localparam logic [2:0] ST_SEED_RED  = 3'd3;
  localparam logic [2:0] ST_MUL       = 3'd4;
  localparam logic [2:0] ST_RED       = 3'd5;
  localparam logic [2:0] ST_MIX       = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            seeded_q, seeded_d;
  clsr_pkg::word_t seed_q, seed_d;
  clsr_pkg::word_t x1_q, x1_d, x2_q, x2_d;
  clsr_pkg::word_t last_q, last_d;
  clsr_pkg::word_t value_q, value_d;
  logic            out_valid_q, out_valid_d;
  logic [AW-1:0]   jsel_q, jsel_d;

  clsr_pkg::word_t x1_next, x2_next, rdata, mix_val;
  logic [AW-1:0]   j_idx;
  logic            mul_en, ram_we, ram_re;
  logic [AW-1:0]   ram_waddr;
  clsr_pkg::word_t ram_wdata;
  logic            advance, accept;
  logic signed [32:0] diff, wrapped;

  clsr_lcg_pair u_lcg (
    .clk_i     (clk_i),
    .mul_en_i  (mul_en),
    .x1_i      (x1_q),
    .x2_i      (x2_q),
    .x1_next_o (x1_next),
    .x2_next_o (x2_next)
  );

  clsr_index #(.TABLE_SIZE(TABLE_SIZE)) u_index (
    .clk_i   (clk_i),
    .value_i (last_q),
    .index_o (j_idx)
  );

  clsr_ram #(.WIDTH(31), .DEPTH(TABLE_SIZE)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (j_idx),
    .rdata_o (rdata)
  );

  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_MIX) && advance);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  assign mul_en = (state_q == ST_SEED_MUL) || (state_q == ST_MUL);
  assign ram_re = (state_q == ST_RED);

  // entry minus second generator, wrapped into 1..SPAN
  always_comb begin
    diff    = $signed({2'b00, rdata}) - $signed({2'b00, x2_q});
    wrapped = (diff < 33'sd1) ? diff + $signed({2'b00, clsr_pkg::SPAN}) : diff;
    mix_val = wrapped[30:0];
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    seeded_d    = seeded_q;
    seed_d      = seed_q;
    x1_d        = x1_q;
    x2_d        = x2_q;
    last_d      = last_q;
    value_d     = value_q;
    out_valid_d = out_valid_q;
    jsel_d      = jsel_q;
    ram_we      = 1'b0;
    ram_waddr   = jsel_q;
    ram_wdata   = x1_q;

    if (cfg_valid_i) begin
      seed_d = seed_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (reseed_i || !seeded_q) ? ST_SEED_INIT : ST_MUL;
        end
      end
      ST_SEED_INIT: begin
        x1_d    = clsr_pkg::reduce_seed(seed_q);
        x2_d    = clsr_pkg::reduce_seed(seed_q);
        cnt_d   = CW'(TABLE_SIZE + clsr_pkg::WARMUP - 1);
        state_d = ST_SEED_MUL;
      end
      ST_SEED_MUL: begin
        state_d = ST_SEED_RED;
      end
      ST_SEED_RED: begin
        x1_d = x1_next;
        // last TABLE_SIZE warm-up steps fill the table, top entry first
        if (cnt_q < CW'(TABLE_SIZE)) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q[AW-1:0];
          ram_wdata = x1_next;
        end
        if (cnt_q == '0) begin
          last_d   = x1_next;
          seeded_d = 1'b1;
          state_d  = ST_MUL;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = ST_SEED_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_RED;
      end
      ST_RED: begin
        x1_d    = x1_next;
        x2_d    = x2_next;
        jsel_d  = j_idx;
        state_d = ST_MIX;
      end
      ST_MIX: begin
        if (advance) begin
          ram_we      = 1'b1;
          last_d      = mix_val;
          value_d     = mix_val;
          out_valid_d = 1'b1;
          if (accept) begin
            state_d = reseed_i ? ST_SEED_INIT : ST_MUL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      seeded_q    <= 1'b0;
      seed_q      <= 31'd1;
      x1_q        <= '0;
      x2_q        <= clsr_pkg::SECOND_RESET;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      seeded_q    <= seeded_d;
      seed_q      <= seed_d;
      x1_q        <= x1_d;
      x2_q        <= x2_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    jsel_q  <= jsel_d;
  end

endmodule

`default_nettype wire

FILE: rtl/clsr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module clsr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [30:0] value_o
);

  // every beat lies in 1..SPAN
  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (value_o != 31'd0) && (value_o <= clsr_pkg::SPAN))
    else $error("output beat out of range");

  // in_ready_o stays low straight after an accepted input beat, while the new draw is under way
  a_draw_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken too soon after a beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(value_o))
    else $error("stalled output beat changed");

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_clsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .value_o     (value_o)
);

`default_nettype wire
